// File: hdl/escalator_travel_controller_macros.svh
// ----------------------------------------------------------------------------
// Escalator travel controller assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef ESCALATOR_TRAVEL_CONTROLLER_MACROS_SVH
`define ESCALATOR_TRAVEL_CONTROLLER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ETC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("etc assertion failed");

// next-cycle implication
`define ETC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("etc assertion failed");

`endif

// File: hdl/etc_pkg.sv
// ----------------------------------------------------------------------------
// Escalator travel controller package
// Phase codes, motor bit positions and the state and sample records.
// ----------------------------------------------------------------------------
package etc_pkg;

    localparam logic [16:0] COUNTER_MOD  = 17'd65535;
    localparam logic [16:0] COUNTER_MOD2 = 17'd131070;
    localparam logic [15:0] TRAVEL_RESET = 16'd60000;

    localparam int MOT_ENABLE_BIT = 0;
    localparam int MOT_LEFT_BIT   = 1;
    localparam int MOT_RIGHT_BIT  = 2;

    localparam logic [2:0] MOT_OFF  = 3'b000;
    localparam logic [2:0] MOT_UP   = 3'b011;
    localparam logic [2:0] MOT_DOWN = 3'b101;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_START_DOWN  = 3'd1,
        PH_START_UP    = 3'd2,
        PH_EMERGENCY   = 3'd3,
        PH_UP_WRAP     = 3'd4,
        PH_UP_NOWRAP   = 3'd5,
        PH_DOWN_WRAP   = 3'd6,
        PH_DOWN_NOWRAP = 3'd7
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] start_pos;
        logic [15:0] end_pos;
        logic [2:0]  motor;
    } ctrl_state_t;

    typedef struct packed {
        logic [15:0] position;
        logic        top_barrier;
        logic        bottom_barrier;
        logic        emergency_stop;
        logic        operate_button;
    } sample_t;

endpackage

// File: hdl/etc_next.sv
// ----------------------------------------------------------------------------
// Escalator next-state logic
// Computes the controller state after one sensor sample.
// ----------------------------------------------------------------------------
module etc_next (
    input  etc_pkg::ctrl_state_t cur,
    input  etc_pkg::sample_t     smp,
    input  logic [15:0]          travel,
    output etc_pkg::ctrl_state_t nxt
);

    logic [16:0]     up_sum;
    logic [16:0]     dn_sum;
    logic [15:0]     up_end;
    logic [15:0]     dn_end;
    etc_pkg::phase_t ph;
    logic [15:0]     pos;

    // sums reach up to twice the modulus
    assign pos    = smp.position;
    assign up_sum = {1'b0, pos} + etc_pkg::COUNTER_MOD - {1'b0, travel};
    assign dn_sum = {1'b0, pos} + {1'b0, travel};
    assign up_end = (up_sum >= etc_pkg::COUNTER_MOD2) ?
                    16'(up_sum - etc_pkg::COUNTER_MOD2) :
                    (up_sum >= etc_pkg::COUNTER_MOD) ?
                    16'(up_sum - etc_pkg::COUNTER_MOD) : up_sum[15:0];
    assign dn_end = (dn_sum >= etc_pkg::COUNTER_MOD2) ?
                    16'(dn_sum - etc_pkg::COUNTER_MOD2) :
                    (dn_sum >= etc_pkg::COUNTER_MOD) ?
                    16'(dn_sum - etc_pkg::COUNTER_MOD) : dn_sum[15:0];

    always_comb
    begin
        nxt = cur;
        ph  = cur.phase;
        if (cur.phase == etc_pkg::PH_EMERGENCY && !smp.operate_button)
        begin
            nxt = cur;
        end
        else if (smp.emergency_stop)
        begin
            nxt.phase = etc_pkg::PH_EMERGENCY;
            nxt.motor = etc_pkg::MOT_OFF;
        end
        else
        begin
            if (smp.operate_button)
            begin
                ph        = etc_pkg::PH_IDLE;
                nxt.phase = etc_pkg::PH_IDLE;
                nxt.motor = etc_pkg::MOT_OFF;
            end
            case (ph)
                etc_pkg::PH_IDLE:
                begin
                    if (smp.top_barrier)
                        nxt.phase = etc_pkg::PH_START_DOWN;
                    else if (smp.bottom_barrier)
                        nxt.phase = etc_pkg::PH_START_UP;
                    nxt.motor = etc_pkg::MOT_OFF;
                end
                etc_pkg::PH_START_UP:
                begin
                    nxt.phase     = (pos < up_end) ? etc_pkg::PH_UP_WRAP
                                                   : etc_pkg::PH_UP_NOWRAP;
                    nxt.start_pos = pos;
                    nxt.end_pos   = up_end;
                    nxt.motor     = etc_pkg::MOT_UP;
                end
                etc_pkg::PH_START_DOWN:
                begin
                    nxt.phase     = (pos > dn_end) ? etc_pkg::PH_DOWN_WRAP
                                                   : etc_pkg::PH_DOWN_NOWRAP;
                    nxt.start_pos = pos;
                    nxt.end_pos   = dn_end;
                    nxt.motor     = etc_pkg::MOT_DOWN;
                end
                etc_pkg::PH_UP_WRAP:
                begin
                    if (smp.bottom_barrier)
                        nxt.phase = etc_pkg::PH_START_UP;
                    else if (pos < cur.end_pos && pos > cur.start_pos)
                        nxt.phase = etc_pkg::PH_IDLE;
                end
                etc_pkg::PH_UP_NOWRAP:
                begin
                    if (smp.bottom_barrier)
                        nxt.phase = etc_pkg::PH_START_UP;
                    else if (pos < cur.end_pos || pos > cur.start_pos)
                        nxt.phase = etc_pkg::PH_IDLE;
                end
                etc_pkg::PH_DOWN_WRAP:
                begin
                    if (smp.top_barrier)
                        nxt.phase = etc_pkg::PH_START_DOWN;
                    else if (pos > cur.end_pos && pos < cur.start_pos)
                        nxt.phase = etc_pkg::PH_IDLE;
                end
                etc_pkg::PH_DOWN_NOWRAP:
                begin
                    if (smp.top_barrier)
                        nxt.phase = etc_pkg::PH_START_DOWN;
                    else if (pos > cur.end_pos || pos < cur.start_pos)
                        nxt.phase = etc_pkg::PH_IDLE;
                end
                default:
                begin
                    nxt.phase = etc_pkg::PH_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/escalator_travel_controller.sv
// ----------------------------------------------------------------------------
// Escalator travel controller
// Sensor samples in, motor command and phase out, one result per sample.
// ----------------------------------------------------------------------------
//  channel   dir  tdata fields (lsb up)
//  s_axis    in   operate_button, emergency_stop, bottom_barrier,
//                 top_barrier, position[15:0]; pad to 24 bits
//  m_axis    out  motor_right, motor_left, motor_enable, phase[2:0]; pad to 8
//  cfg       in   travel_distance[15:0] on cfg_we
//
//  One word per cycle sustained while m_tready is high; the input register
//  feeds the next-state logic into the state and result registers.
//  rst_n clears phase, positions, motors, valids; travel returns to 60000.
//  A stalled result holds; the input register still fills, and a
//  new word is taken once the result register frees or drains.
// ----------------------------------------------------------------------------
module escalator_travel_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // operate, emergency, bottom, top, position
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // right, left, enable, phase[2:0]
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);

    logic                 in_valid_reg;
    etc_pkg::sample_t     in_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_data_reg;
    etc_pkg::ctrl_state_t state_reg;
    etc_pkg::ctrl_state_t state_next;
    logic [15:0]          travel_reg;
    logic                 advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    etc_next u_next (
        .cur    (state_reg),
        .smp    (in_reg),
        .travel (travel_reg),
        .nxt    (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            travel_reg <= etc_pkg::TRAVEL_RESET;
        else if (cfg_we)
            travel_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_reg <= etc_pkg::sample_t'(s_tdata[19:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{phase: etc_pkg::PH_IDLE, start_pos: 16'd0,
                               end_pos: 16'd0, motor: etc_pkg::MOT_OFF};
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            out_data_reg <= {2'b00, state_next.phase,
                             state_next.motor[etc_pkg::MOT_ENABLE_BIT],
                             state_next.motor[etc_pkg::MOT_LEFT_BIT],
                             state_next.motor[etc_pkg::MOT_RIGHT_BIT]};
    end

endmodule

// File: hdl/etc_checker.sv
// ----------------------------------------------------------------------------
// Escalator travel controller port checker
// Watches the top-level ports for motor command consistency and stalls.
// ----------------------------------------------------------------------------
`include "escalator_travel_controller_macros.svh"

module etc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    logic emerg_out;

    assign emerg_out = m_tvalid && (m_tdata[5:3] == etc_pkg::PH_EMERGENCY);

    // emergency always reports motors off
    `ETC_ASSERT_NOW(a_emerg_motors_off, emerg_out, m_tdata[2:0] == 3'b000)

    // never both directions at once
    `ETC_ASSERT_NOW(a_one_direction, m_tvalid, !(m_tdata[0] && m_tdata[1]))

    // a direction is only commanded with power on
    `ETC_ASSERT_NOW(a_dir_needs_enable, m_tvalid && (m_tdata[0] || m_tdata[1]),
                    m_tdata[2])

    // stalled result word holds
    `ETC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata))

endmodule

bind escalator_travel_controller etc_checker u_etc_checker (.*);
